### sv/sev_pkg.sv
// Package for the sound-effect voice: widths, register and waveform codes,
// reset values and the quarter-sine function used to build the sine table.
// No dependencies.
`default_nettype none

package sev_pkg;

    localparam int MAG_W      = 15;              // magnitude of a raw sample, 0..16384
    localparam int FRAME_W    = 16;              // sample index / length
    localparam int PROD_W     = MAG_W + FRAME_W; // magnitude * remaining frames
    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int WAVE_W     = 2;
    localparam int STEP_W     = 24;
    localparam int NOISE_W    = 16;

    localparam int DEF_PHASE_BITS      = 24;
    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_MAX_FRAMES      = 44100;

    localparam logic [MAG_W-1:0]   SQUARE_LEVEL   = 15'd9830;
    localparam logic [NOISE_W-1:0] NOISE_TAPS     = 16'hB400;
    localparam logic [NOISE_W-1:0] NOISE_SEED     = 16'hFFFF;
    localparam logic [STEP_W-1:0]  RST_PHASE_STEP = 24'd152174;
    localparam logic [FRAME_W-1:0] RST_LENGTH     = 16'd6615;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVEFORM      = 2'd0,
        REG_PHASE_STEP    = 2'd1,
        REG_LENGTH_FRAMES = 2'd2
    } cfg_reg_t;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SQUARE = 2'd0,
        WAVE_NOISE  = 2'd1,
        WAVE_SINE   = 2'd2
    } wave_t;

    // request into the serial fade unit
    typedef struct packed {
        logic               start;
        logic [MAG_W-1:0]   mag;
        logic [FRAME_W-1:0] factor;
        logic [FRAME_W-1:0] divisor;
    } fade_req_t;

    // Q30 Taylor evaluation of 16384*sin(pi/2 * q / 2^(tb-2)); elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned q,
                                                      input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (64'(q) * HALF_PI_Q30) >> (tb - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (s * 64'd16384 + (Q30_ONE >> 1)) >> 30;
        if (r > 64'd16384) begin
            r = 64'd16384;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/sev_sine_rom.sv
// Quarter-wave sine table with registered read.
// Depends on sev_pkg (quarter_sine, MAG_W).
`default_nettype none

module sev_sine_rom
    import sev_pkg::*;
#(
    parameter int TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  rd_en,
    input  wire logic [TABLE_BITS-2:0] rd_addr,
    output logic      [MAG_W-1:0]      rd_data
);

    localparam int QSIZE = 1 << (TABLE_BITS - 2);

    logic [MAG_W-1:0] rom [0:QSIZE];
    logic [MAG_W-1:0] rd_data_reg;

    for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
        localparam logic [MAG_W-1:0] VAL = quarter_sine(g, TABLE_BITS);
        assign rom[g] = VAL;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/sev_fade_unit.sv
// Bit-serial fade: quotient = mag * factor / divisor, truncated.
// Shift-add multiply, one multiplier bit a cycle, then restoring divide in
// the same shift register, one quotient bit a cycle. Depends on sev_pkg.
`default_nettype none

module sev_fade_unit
    import sev_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire fade_req_t        req,
    output logic                  done,
    output logic      [MAG_W-1:0] quot
);

    localparam int CNT_W = $clog2(FRAME_W);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIV  = 4'b0100,
        F_DONE = 4'b1000
    } fstate_t;

    fstate_t            state_reg,  state_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [PROD_W-1:0]  acc_reg,    acc_next;
    logic [FRAME_W-1:0] fac_reg,    fac_next;
    logic [MAG_W-1:0]   mag_reg,    mag_next;
    logic [FRAME_W-1:0] div_reg,    div_next;

    logic [FRAME_W:0]   trial;
    logic [FRAME_W:0]   diff;
    logic               ge;
    logic [FRAME_W-1:0] rem_new;

    // divide step: remainder sits in the top FRAME_W bits, quotient enters at the bottom
    assign trial   = {acc_reg[PROD_W-1:MAG_W], acc_reg[MAG_W-1]};
    assign diff    = trial - {1'b0, div_reg};
    assign ge      = (trial >= {1'b0, div_reg});
    assign rem_new = ge ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        fac_next   = fac_reg;
        mag_next   = mag_reg;
        div_next   = div_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    acc_next   = '0;
                    fac_next   = req.factor;
                    mag_next   = req.mag;
                    div_next   = req.divisor;
                    cnt_next   = '0;
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (fac_reg[FRAME_W-1] ? PROD_W'(mag_reg) : PROD_W'(0));
                fac_next = {fac_reg[FRAME_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAME_W - 1)) begin
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                acc_next = {rem_new, acc_reg[MAG_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                    cnt_next   = '0;
                    state_next = F_DONE;
                end
            end
            F_DONE: begin
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        fac_reg <= fac_next;
        mag_reg <= mag_next;
        div_reg <= div_next;
    end

    assign done = (state_reg == F_DONE);
    assign quot = acc_reg[MAG_W-1:0];

endmodule

`default_nettype wire

### sv/sound_effect_voice_unit.sv
// Sound-effect voice top level: square, noise or sine source with linear fade-out.
// Depends on sev_pkg, sev_sine_rom, sev_fade_unit.
// Flow: a sounding beat goes from T_LOAD through the bit-serial fade (load, 16 multiply steps,
// 15 divide steps, done) to T_OUT and the output register; a silent beat goes straight to T_OUT.
// Handshake: one beat in flight; no new beat until the result leaves T_OUT, which m_ready can stall.
// Reset (aresetn low, synchronous): registers to defaults, index/phase 0, noise all ones.
`default_nettype none

module sound_effect_voice_unit
    import sev_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
    parameter int MAX_FRAMES      = DEF_MAX_FRAMES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // tick input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_restart,
    // sample output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [SAMPLE_W-1:0]   m_sample,
    output logic                       m_last,
    output logic                       m_silent
);

    localparam logic [FRAME_W-1:0] MAX_LEN = FRAME_W'(MAX_FRAMES);
    localparam int                 TB      = SINE_TABLE_BITS;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,   // waiting for a tick
        T_LOAD = 4'b0010,   // table data ready, kick the fade unit
        T_FADE = 4'b0100,   // serial multiply/divide running
        T_OUT  = 4'b1000    // result ready, waiting for a free output register
    } state_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [WAVE_W-1:0]  waveform_reg;
    logic [STEP_W-1:0]  phase_step_reg;
    logic [FRAME_W-1:0] length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waveform_reg   <= WAVE_SQUARE;
            phase_step_reg <= RST_PHASE_STEP;
            length_reg     <= RST_LENGTH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WAVEFORM:      waveform_reg   <= cfg_wr_data[WAVE_W-1:0];
                REG_PHASE_STEP:    phase_step_reg <= cfg_wr_data[STEP_W-1:0];
                REG_LENGTH_FRAMES: length_reg     <= cfg_wr_data[FRAME_W-1:0];
                default: ;         // unmapped index: ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // voice state and control
    // ---------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [FRAME_W-1:0]    index_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [NOISE_W-1:0]    noise_reg;

    // per-beat working registers
    logic                  silent_reg;
    logic                  last_reg;
    logic                  neg_reg;
    logic                  is_sine_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [FRAME_W-1:0]    factor_reg;
    logic [FRAME_W-1:0]    len_reg;
    logic [SAMPLE_W-1:0]   res_sample_reg;

    // output register
    logic                  m_valid_reg;
    logic [SAMPLE_W-1:0]   m_sample_reg;
    logic                  m_last_reg;
    logic                  m_silent_reg;

    logic                  accept;
    logic                  out_load;
    logic [FRAME_W-1:0]    len_sat;
    logic [FRAME_W-1:0]    index_eff;
    logic [PHASE_BITS-1:0] phase_eff;
    logic                  is_silent;
    logic [63:0]           step_wide;
    logic [PHASE_BITS-1:0] step_ext;

    assign s_ready  = (state_reg == T_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == T_OUT) && (!m_valid_reg || m_ready);

    // length clamps to the build-time maximum; restart clears index and phase first
    assign len_sat   = (length_reg > MAX_LEN) ? MAX_LEN : length_reg;
    assign index_eff = s_restart ? '0 : index_reg;
    assign phase_eff = s_restart ? '0 : phase_reg;
    assign is_silent = (index_eff >= len_sat);
    // only the low PHASE_BITS of the step count (zero-extended when wider)
    assign step_wide = 64'(phase_step_reg);
    assign step_ext  = step_wide[PHASE_BITS-1:0];

    // ---------------------------------------------------------------
    // raw sources
    // ---------------------------------------------------------------
    // noise: (lfsr - 32768) >>> 2, split into sign and magnitude
    logic [NOISE_W-1:0] centered;
    logic [NOISE_W-1:0] noise_raw;
    logic [NOISE_W-1:0] noise_abs;
    logic [NOISE_W-1:0] noise_adv;

    assign centered  = {~noise_reg[NOISE_W-1], noise_reg[NOISE_W-2:0]};
    assign noise_raw = {{2{centered[NOISE_W-1]}}, centered[NOISE_W-1:2]};
    assign noise_abs = centered[NOISE_W-1] ? (NOISE_W'(0) - noise_raw) : noise_raw;
    assign noise_adv = noise_reg[0] ? ((noise_reg >> 1) ^ NOISE_TAPS) : (noise_reg >> 1);

    // sine: quadrant folding onto the quarter table
    logic [TB-1:0] sine_k;
    logic [1:0]    sine_quad;
    logic [TB-2:0] sine_pos;
    logic [TB-2:0] sine_addr;
    logic [MAG_W-1:0] sine_mag;

    assign sine_k    = phase_eff[PHASE_BITS-1 -: TB];
    assign sine_quad = sine_k[TB-1:TB-2];
    assign sine_pos  = {1'b0, sine_k[TB-3:0]};
    assign sine_addr = sine_quad[0] ? ({1'b1, {(TB-2){1'b0}}} - sine_pos) : sine_pos;

    sev_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (sine_addr),
        .rd_data (sine_mag)
    );

    // ---------------------------------------------------------------
    // fade unit
    // ---------------------------------------------------------------
    fade_req_t        fade_req;
    logic             fade_done;
    logic [MAG_W-1:0] fade_quot;

    always_comb begin
        fade_req.start   = (state_reg == T_LOAD);
        fade_req.mag     = is_sine_reg ? sine_mag : mag_reg;
        fade_req.factor  = factor_reg;
        fade_req.divisor = len_reg;
    end

    sev_fade_unit u_fade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fade_req),
        .done    (fade_done),
        .quot    (fade_quot)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (accept)    state_next = is_silent ? T_OUT : T_LOAD;
            T_LOAD:                state_next = T_FADE;
            T_FADE: if (fade_done) state_next = T_OUT;
            T_OUT:  if (out_load)  state_next = T_IDLE;
            default:               state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            index_reg   <= '0;
            phase_reg   <= '0;
            noise_reg   <= NOISE_SEED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                // a silent tick still takes the restart, nothing advances
                index_reg <= is_silent ? index_eff : index_eff + 1'b1;
                phase_reg <= is_silent ? phase_eff : phase_eff + step_ext;
                if (!is_silent && waveform_reg == WAVE_NOISE) begin
                    noise_reg <= noise_adv;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload path, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            silent_reg  <= is_silent;
            last_reg    <= !is_silent && (index_eff == len_sat - 1'b1);
            factor_reg  <= len_sat - index_eff;
            len_reg     <= len_sat;
            unique case (waveform_reg)
                WAVE_SQUARE: begin
                    neg_reg     <= phase_eff[PHASE_BITS-1];
                    mag_reg     <= SQUARE_LEVEL;
                    is_sine_reg <= 1'b0;
                end
                WAVE_NOISE: begin
                    neg_reg     <= centered[NOISE_W-1];
                    mag_reg     <= noise_abs[MAG_W-1:0];
                    is_sine_reg <= 1'b0;
                end
                default: begin  // sine, and the spare code also plays sine
                    neg_reg     <= sine_quad[1];
                    mag_reg     <= '0;
                    is_sine_reg <= 1'b1;
                end
            endcase
            if (is_silent) begin
                res_sample_reg <= '0;
            end
        end
        if (state_reg == T_FADE && fade_done) begin
            res_sample_reg <= neg_reg ? (SAMPLE_W'(0) - SAMPLE_W'(fade_quot))
                                      : SAMPLE_W'(fade_quot);
        end
        if (out_load) begin
            m_sample_reg <= res_sample_reg;
            m_last_reg   <= last_reg;
            m_silent_reg <= silent_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_last   = m_last_reg;
    assign m_silent = m_silent_reg;

endmodule

`default_nettype wire

### sv/sev_checker.sv
// Port-level checks for the sound-effect voice, bound to the top level.
// Depends on sev_pkg.
`default_nettype none

module sev_checker
    import sev_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [SAMPLE_W-1:0] m_sample,
    input wire logic                m_last,
    input wire logic                m_silent
);

    // a silent beat carries a zero sample and never flags last
    a_silent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_silent) |-> (m_sample == '0 && !m_last))
        else $error("silent beat with nonzero sample or last set");

    // one tick in flight: input side closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second tick taken while one is in flight");

    // a result never appears the cycle right after its tick
    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared without processing time");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample)
                                   && $stable(m_last) && $stable(m_silent)))
        else $error("stalled result dropped or changed");

endmodule

bind sound_effect_voice_unit sev_checker u_sev_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_sample (m_sample),
    .m_last   (m_last),
    .m_silent (m_silent)
);

`default_nettype wire
